// ===== hw/rtl/cigar_alignment_span_defines.svh =====
// assertion macros for the cigar span block
`ifndef CIGAR_ALIGNMENT_SPAN_DEFINES_SVH
`define CIGAR_ALIGNMENT_SPAN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CAS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication, checked outside reset
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== hw/rtl/cas_pkg.sv =====
// shared types and constants for the cigar span block
package cas_pkg;

   localparam int LEN_W       = 28;
   localparam int POS_W       = 31;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_M  = 4'd0,
      OP_I  = 4'd1,
      OP_D  = 4'd2,
      OP_N  = 4'd3,
      OP_S  = 4'd4,
      OP_H  = 4'd5,
      OP_P  = 4'd6,
      OP_EQ = 4'd7,
      OP_X  = 4'd8
   } op_code_type;

   typedef struct packed {
      logic ref_use;
      logic query_use;
      logic aligned;
      logic soft_clip;
      logic bad;
   } op_class_type;

   typedef struct packed {
      op_class_type            cls;
      logic [LEN_W-1:0]        len;
      logic [POS_W-1:0]        start;
      logic                    start_sat;
      logic                    reverse;
      logic                    last;
   } element_type;

   typedef struct packed {
      logic        valid;
      element_type element;
   } queue_status_type;

endpackage

// ===== hw/rtl/cas_front.sv =====
// front end: classifies each cigar element and clamps the reference start
module cas_front #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [3:0]                req_op_code,
   input  logic [cas_pkg::LEN_W-1:0] req_op_length,
   input  logic [cas_pkg::POS_W-1:0] req_ref_start,
   input  logic                      req_reverse_strand,
   input  logic                      req_last_element,
   input  logic                      queue_ready,
   output logic                      push,
   output cas_pkg::element_type      element
);
   import cas_pkg::*;

   localparam int VAL_W = (ACC_WIDTH >= 32) ? 31 : ACC_WIDTH - 1;
   localparam logic [POS_W-1:0] START_LIMIT = POS_W'((64'd1 << VAL_W) - 64'd1);

   op_class_type cls;

   always_comb begin
      cls = '0;
      unique case (op_code_type'(req_op_code)) inside
         OP_M, OP_EQ, OP_X: begin
            cls.ref_use   = 1'b1;
            cls.query_use = 1'b1;
            cls.aligned   = 1'b1;
         end
         OP_I: begin
            cls.query_use = 1'b1;
            cls.aligned   = 1'b1;
         end
         OP_D, OP_N: begin
            cls.ref_use = 1'b1;
         end
         OP_S: begin
            cls.query_use = 1'b1;
            cls.soft_clip = 1'b1;
         end
         OP_H, OP_P: begin
         end
         default: begin
            cls.bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      element.cls       = cls;
      element.len       = req_op_length;
      element.start_sat = (req_ref_start > START_LIMIT);
      element.start     = element.start_sat ? START_LIMIT : req_ref_start;
      element.reverse   = req_reverse_strand;
      element.last      = req_last_element;
   end

   assign req_ready = queue_ready;
   assign push      = req_valid & queue_ready;

endmodule

// ===== hw/rtl/cas_queue.sv =====
// short queue of classified elements between front and back
module cas_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cas_pkg::element_type      push_element,
   output logic                      ready,
   input  logic                      pop,
   output cas_pkg::queue_status_type status
);
   import cas_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   element_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign ready          = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign status.valid   = (count_ff != '0);
   assign status.element = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_element;
      end
   end

endmodule

// ===== hw/rtl/cas_back.sv =====
// back end: saturating span accumulators and result register
module cas_back #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cas_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [cas_pkg::POS_W-1:0] rsp_ref_end,
   output logic [cas_pkg::POS_W-1:0] rsp_query_start,
   output logic [cas_pkg::POS_W-1:0] rsp_query_end,
   output logic [cas_pkg::POS_W-1:0] rsp_query_length,
   output logic [cas_pkg::POS_W-1:0] rsp_left_clip,
   output logic [cas_pkg::POS_W-1:0] rsp_right_clip,
   output logic                      rsp_bad_op_seen,
   output logic                      rsp_overflow
);
   import cas_pkg::*;

   localparam int VAL_W = (ACC_WIDTH >= 32) ? 31 : ACC_WIDTH - 1;
   localparam int SUM_W = ((VAL_W > LEN_W) ? VAL_W : LEN_W) + 1;
   localparam logic [VAL_W-1:0] LIMIT_VAL = {VAL_W{1'b1}};
   localparam logic [SUM_W-1:0] LIMIT_SUM = SUM_W'(LIMIT_VAL);

   // {saturated, value}
   function automatic logic [VAL_W:0] sat_add(input logic [VAL_W-1:0] a,
                                              input logic [LEN_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s > LIMIT_SUM) begin
         return {1'b1, LIMIT_VAL};
      end
      return {1'b0, s[VAL_W-1:0]};
   endfunction

   element_type e;

   logic [VAL_W-1:0] ref_ff, ref_in, qlen_ff, qlen_in;
   logic [VAL_W-1:0] lead_ff, lead_in, trail_ff, trail_in;
   logic aligned_ff, aligned_in, mid_ff, mid_in, strand_ff, strand_in;
   logic bad_ff, bad_in, sat_ff, sat_in;

   logic [VAL_W-1:0] base_ref, base_qlen, base_lead, base_trail;
   logic base_aligned, base_sat, base_bad, base_strand;
   logic [VAL_W:0] ref_sum, qlen_sum, lead_sum, trail_sum;
   logic emit;

   logic rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] out_ref_ff, out_qlen_ff, out_lead_ff, out_trail_ff;
   logic out_strand_ff, out_bad_ff, out_sat_ff;
   logic [VAL_W-1:0] qs, clip;

   assign e    = status.element;
   assign pop  = status.valid & (~e.last | ~rsp_valid_ff | rsp_ready);
   assign emit = pop & e.last;

   always_comb begin
      // first element of a segment starts from the sampled start
      base_ref     = mid_ff ? ref_ff     : e.start[VAL_W-1:0];
      base_qlen    = mid_ff ? qlen_ff    : '0;
      base_lead    = mid_ff ? lead_ff    : '0;
      base_trail   = mid_ff ? trail_ff   : '0;
      base_aligned = mid_ff ? aligned_ff : 1'b0;
      base_sat     = mid_ff ? sat_ff     : e.start_sat;
      base_bad     = mid_ff ? bad_ff     : 1'b0;
      base_strand  = mid_ff ? strand_ff  : e.reverse;

      ref_sum   = sat_add(base_ref, e.len);
      qlen_sum  = sat_add(base_qlen, e.len);
      lead_sum  = sat_add(base_lead, e.len);
      trail_sum = sat_add(base_trail, e.len);

      ref_in     = base_ref;
      qlen_in    = base_qlen;
      lead_in    = base_lead;
      trail_in   = base_trail;
      aligned_in = base_aligned | e.cls.aligned;
      sat_in     = base_sat;
      bad_in     = base_bad | e.cls.bad;
      strand_in  = base_strand;

      if (e.cls.ref_use) begin
         ref_in = ref_sum[VAL_W-1:0];
         sat_in = sat_in | ref_sum[VAL_W];
      end
      if (e.cls.query_use) begin
         qlen_in = qlen_sum[VAL_W-1:0];
         sat_in  = sat_in | qlen_sum[VAL_W];
      end
      if (e.cls.soft_clip) begin
         trail_in = trail_sum[VAL_W-1:0];
         sat_in   = sat_in | trail_sum[VAL_W];
         if (!base_aligned) begin
            lead_in = lead_sum[VAL_W-1:0];
            sat_in  = sat_in | lead_sum[VAL_W];
         end
      end
      if (e.cls.aligned) begin
         trail_in = '0;
      end

      mid_in = ~e.last;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= '0;
         qlen_ff      <= '0;
         lead_ff      <= '0;
         trail_ff     <= '0;
         aligned_ff   <= 1'b0;
         mid_ff       <= 1'b0;
         strand_ff    <= 1'b0;
         bad_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            ref_ff     <= ref_in;
            qlen_ff    <= qlen_in;
            lead_ff    <= lead_in;
            trail_ff   <= trail_in;
            aligned_ff <= aligned_in;
            mid_ff     <= mid_in;
            strand_ff  <= strand_in;
            bad_ff     <= bad_in;
            sat_ff     <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ref_ff    <= ref_in;
         out_qlen_ff   <= qlen_in;
         out_lead_ff   <= lead_in;
         out_trail_ff  <= trail_in;
         out_strand_ff <= strand_in;
         out_bad_ff    <= bad_in;
         out_sat_ff    <= sat_in;
      end
   end

   // strand picks which clip opens the query range
   assign qs   = out_strand_ff ? out_trail_ff : out_lead_ff;
   assign clip = out_strand_ff ? out_lead_ff  : out_trail_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ref_end      = POS_W'(out_ref_ff);
   assign rsp_query_start  = POS_W'(qs);
   assign rsp_query_end    = (clip > out_qlen_ff) ? '0 : POS_W'(out_qlen_ff - clip);
   assign rsp_query_length = POS_W'(out_qlen_ff);
   assign rsp_left_clip    = POS_W'(out_lead_ff);
   assign rsp_right_clip   = POS_W'(out_trail_ff);
   assign rsp_bad_op_seen  = out_bad_ff;
   assign rsp_overflow     = out_sat_ff;

endmodule

// ===== hw/rtl/cigar_alignment_span.sv =====
// top level of the cigar reference and query span block
// takes one cigar element per transaction and sustains one element per clock
// while the back end is not stalled; the accumulators in the back end close
// their saturating add combinationally, so back-to-back elements of a segment
// never wait on each other. the segment result is registered when its last
// element leaves the head of the element queue (acceptance writes the queue,
// the pop of that element loads the result register and raises rsp_valid).
// the result register holds a finished segment while the next segment's
// elements keep flowing; the back end stalls only when a second result is
// ready and the first has not been taken, and the two-entry queue, whose head
// then holds the stalled element, absorbs at most one more element before req_ready
// drops.
// sums saturate at 2^31-1 (or 2^(ACC_WIDTH-1)-1 for narrower accumulators)
// and set rsp_overflow; unknown op codes change nothing and set
// rsp_bad_op_seen.
`include "cigar_alignment_span_defines.svh"

module cigar_alignment_span #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [3:0]                req_op_code,
   input  logic [cas_pkg::LEN_W-1:0] req_op_length,
   input  logic [cas_pkg::POS_W-1:0] req_ref_start,
   input  logic                      req_reverse_strand,
   input  logic                      req_last_element,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [cas_pkg::POS_W-1:0] rsp_ref_end,
   output logic [cas_pkg::POS_W-1:0] rsp_query_start,
   output logic [cas_pkg::POS_W-1:0] rsp_query_end,
   output logic [cas_pkg::POS_W-1:0] rsp_query_length,
   output logic [cas_pkg::POS_W-1:0] rsp_left_clip,
   output logic [cas_pkg::POS_W-1:0] rsp_right_clip,
   output logic                      rsp_bad_op_seen,
   output logic                      rsp_overflow
);
   import cas_pkg::*;

   // front to queue
   logic             queue_ready;
   logic             push;
   element_type      push_element;

   // queue to back
   queue_status_type q_status;
   logic             pop;

   // decode and clamp, no storage
   cas_front #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op_code        (req_op_code),
      .req_op_length      (req_op_length),
      .req_ref_start      (req_ref_start),
      .req_reverse_strand (req_reverse_strand),
      .req_last_element   (req_last_element),
      .queue_ready        (queue_ready),
      .push               (push),
      .element            (push_element)
   );

   // decouples the front from back-end stalls
   cas_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_element (push_element),
      .ready        (queue_ready),
      .pop          (pop),
      .status       (q_status)
   );

   // accumulators and result register
   cas_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ref_end      (rsp_ref_end),
      .rsp_query_start  (rsp_query_start),
      .rsp_query_end    (rsp_query_end),
      .rsp_query_length (rsp_query_length),
      .rsp_left_clip    (rsp_left_clip),
      .rsp_right_clip   (rsp_right_clip),
      .rsp_bad_op_seen  (rsp_bad_op_seen),
      .rsp_overflow     (rsp_overflow)
   );

   // the back end never pops an empty queue
   `CAS_ASSERT_IMPLIES(a_pop_needs_entry, clock, reset, pop, q_status.valid)
   // a full queue always offers an element to the back end
   `CAS_ASSERT_IMPLIES(a_full_has_entry, clock, reset, !req_ready, q_status.valid)
   // clips never exceed the query length of the segment
   `CAS_ASSERT_IMPLIES(a_clip_bound, clock, reset, rsp_valid,
                       rsp_left_clip <= rsp_query_length && rsp_right_clip <= rsp_query_length)
   // the query range stays inside the query
   `CAS_ASSERT_IMPLIES(a_query_range, clock, reset, rsp_valid,
                       rsp_query_end <= rsp_query_length)

endmodule
